// ===== rtl/core/rc4_pkg.sv =====
// shared types and constants for the rc4 stream cipher
`timescale 1ns / 1ps
`default_nettype none
package rc4_pkg;

	localparam int unsigned TableSize = 256;
	localparam int unsigned KeyMax    = 256;
	localparam int unsigned AddrW     = 8;
	localparam int unsigned ByteW     = 8;
	localparam int unsigned CountW    = 9;

	localparam logic REQ_KEY  = 1'b0;
	localparam logic REQ_DATA = 1'b1;

	typedef enum logic [3:0] {
		ST_FILL,
		ST_IDLE,
		ST_D_RD_J,
		ST_D_RD_T,
		ST_D_OUT,
		ST_K_RD,
		ST_K_SUM,
		ST_K_WR_N,
		ST_K_WR_J
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/core/rc4_if.sv =====
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface rc4_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] data_byte;
	logic       last_key;

	modport source (output valid, req_type, data_byte, last_key, input ready);
	modport sink (input valid, req_type, data_byte, last_key, output ready);
endinterface

interface rc4_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] cipher_byte;

	modport source (output valid, cipher_byte, input ready);
	modport sink (input valid, cipher_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rc4_stream_cipher_top.sv =====
// rc4 stream cipher top level: key collection, key schedule and keystream xor
//
// req channel: req_type 0 stores data_byte as the next key byte (bytes past
// 256 are dropped); last_key on a key byte runs the key schedule. req_type 1
// is a data byte, answered by one transfer on rsp with cipher_byte = data
// xor keystream. key bytes give no response.
// the permutation lives in a 256 x 8 ram with one read and one write port,
// the key in a second ram. a data byte runs read s[i], read s[j], write s[i]
// while reading s[s[i]+s[j]], write s[j]; the result register is loaded as
// the step writing s[j] completes, then the block returns to idle for the
// next request. the last key byte starts an identity fill of the ram, then
// 256 swap rounds (read s[n] and the key byte, read s[j], write s[n], write
// s[j]), all on the single ram write port.
// after reset the block fills the identity permutation
// with req.ready low, indices cleared and the key empty.
// a result waits in the output register; while rsp is stalled the block
// still takes key bytes, and a data byte holds in its last step until the
// previous result has been taken.
`timescale 1ns / 1ps
`default_nettype none
module rc4_stream_cipher_top (
	input wire logic clk,
	input wire logic arst_n,
	rc4_req_if.sink   req,
	rc4_rsp_if.source rsp
);

	rc4_pkg::state_t state_q, state_d;

	logic [rc4_pkg::AddrW-1:0]  i_q, j_q, n_q, kidx_q, t_q;
	logic [rc4_pkg::ByteW-1:0]  si_q, sj_q, byte_q, cipher_q;
	logic [rc4_pkg::CountW-1:0] kcnt_q, len_q;
	logic                       sched_q, out_valid_q;

	// permutation ram ports
	logic                      s_we, s_re;
	logic [rc4_pkg::AddrW-1:0] s_waddr, s_raddr;
	logic [rc4_pkg::ByteW-1:0] s_wdata, s_rdata;
	// key ram ports
	logic                      k_we, k_re;
	logic [rc4_pkg::AddrW-1:0] k_waddr, k_raddr;
	logic [rc4_pkg::ByteW-1:0] k_wdata, k_rdata;

	logic                       acc, key_acc, data_acc, key_room, out_free;
	logic [rc4_pkg::CountW-1:0] kcnt_next;
	logic [rc4_pkg::AddrW-1:0]  i_inc, j_sum, jj_sum, t_sum;
	logic [rc4_pkg::ByteW-1:0]  ks_byte;

	rc4_ram #(.WIDTH(rc4_pkg::ByteW), .DEPTH(rc4_pkg::TableSize)) u_perm_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.re    (s_re),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	rc4_ram #(.WIDTH(rc4_pkg::ByteW), .DEPTH(rc4_pkg::TableSize)) u_key_ram (
		.clk   (clk),
		.we    (k_we),
		.waddr (k_waddr),
		.wdata (k_wdata),
		.re    (k_re),
		.raddr (k_raddr),
		.rdata (k_rdata)
	);

	assign req.ready = (state_q == rc4_pkg::ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign key_acc   = acc && (req.req_type == rc4_pkg::REQ_KEY);
	assign data_acc  = acc && (req.req_type == rc4_pkg::REQ_DATA);
	assign key_room  = (kcnt_q < rc4_pkg::CountW'(rc4_pkg::KeyMax));
	assign kcnt_next = key_room ? kcnt_q + rc4_pkg::CountW'(1) : kcnt_q;
	assign out_free  = !out_valid_q || rsp.ready;

	assign i_inc  = i_q + rc4_pkg::AddrW'(1);
	assign j_sum  = j_q + s_rdata;
	assign jj_sum = j_q + s_rdata + k_rdata;
	assign t_sum  = si_q + s_rdata;

	// s[t] after the swap: s[j] was written last, then s[i], else ram data
	always_comb begin
		priority if (t_q == j_q) begin
			ks_byte = si_q;
		end else if (t_q == i_q) begin
			ks_byte = sj_q;
		end else begin
			ks_byte = s_rdata;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.cipher_byte = cipher_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rc4_pkg::ST_FILL: begin
				if (n_q == rc4_pkg::AddrW'(rc4_pkg::TableSize - 1)) begin
					state_d = sched_q ? rc4_pkg::ST_K_RD : rc4_pkg::ST_IDLE;
				end
			end
			rc4_pkg::ST_IDLE: begin
				if (data_acc) begin
					state_d = rc4_pkg::ST_D_RD_J;
				end else if (key_acc && req.last_key) begin
					state_d = rc4_pkg::ST_FILL;
				end
			end
			rc4_pkg::ST_D_RD_J: state_d = rc4_pkg::ST_D_RD_T;
			rc4_pkg::ST_D_RD_T: state_d = rc4_pkg::ST_D_OUT;
			rc4_pkg::ST_D_OUT: begin
				if (out_free) begin
					state_d = rc4_pkg::ST_IDLE;
				end
			end
			rc4_pkg::ST_K_RD:   state_d = rc4_pkg::ST_K_SUM;
			rc4_pkg::ST_K_SUM:  state_d = rc4_pkg::ST_K_WR_N;
			rc4_pkg::ST_K_WR_N: state_d = rc4_pkg::ST_K_WR_J;
			rc4_pkg::ST_K_WR_J: begin
				state_d = (n_q == rc4_pkg::AddrW'(rc4_pkg::TableSize - 1)) ?
					rc4_pkg::ST_IDLE : rc4_pkg::ST_K_RD;
			end
			default: state_d = rc4_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		s_we    = 1'b0;
		s_waddr = n_q;
		s_wdata = n_q;
		s_re    = 1'b0;
		s_raddr = i_inc;
		k_we    = 1'b0;
		k_waddr = kcnt_q[rc4_pkg::AddrW-1:0];
		k_wdata = req.data_byte;
		k_re    = 1'b0;
		k_raddr = kidx_q;
		unique case (state_q)
			rc4_pkg::ST_FILL: begin
				s_we = 1'b1;
			end
			rc4_pkg::ST_IDLE: begin
				k_we    = key_acc && key_room;
				s_re    = data_acc;
				s_raddr = i_inc;
			end
			rc4_pkg::ST_D_RD_J: begin
				s_re    = 1'b1;
				s_raddr = j_sum;
			end
			rc4_pkg::ST_D_RD_T: begin
				s_we    = 1'b1;
				s_waddr = i_q;
				s_wdata = s_rdata;
				s_re    = 1'b1;
				s_raddr = t_sum;
			end
			rc4_pkg::ST_D_OUT: begin
				s_we    = 1'b1;
				s_waddr = j_q;
				s_wdata = si_q;
			end
			rc4_pkg::ST_K_RD: begin
				s_re    = 1'b1;
				s_raddr = n_q;
				k_re    = 1'b1;
			end
			rc4_pkg::ST_K_SUM: begin
				s_re    = 1'b1;
				s_raddr = jj_sum;
			end
			rc4_pkg::ST_K_WR_N: begin
				s_we    = 1'b1;
				s_waddr = n_q;
				s_wdata = s_rdata;
			end
			rc4_pkg::ST_K_WR_J: begin
				s_we    = 1'b1;
				s_waddr = j_q;
				s_wdata = si_q;
			end
			default: begin
				s_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rc4_pkg::ST_FILL;
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			kidx_q      <= '0;
			kcnt_q      <= '0;
			len_q       <= '0;
			sched_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// a new result may replace one taken at the same edge
			if (state_q == rc4_pkg::ST_D_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				rc4_pkg::ST_FILL: begin
					n_q <= n_q + rc4_pkg::AddrW'(1);
				end
				rc4_pkg::ST_IDLE: begin
					if (data_acc) begin
						i_q <= i_inc;
					end else if (key_acc) begin
						if (req.last_key) begin
							kcnt_q  <= '0;
							len_q   <= kcnt_next;
							sched_q <= 1'b1;
							n_q     <= '0;
							kidx_q  <= '0;
							j_q     <= '0;
						end else begin
							kcnt_q <= kcnt_next;
						end
					end
				end
				rc4_pkg::ST_D_RD_J: begin
					j_q <= j_sum;
				end
				rc4_pkg::ST_K_SUM: begin
					j_q <= jj_sum;
				end
				rc4_pkg::ST_K_WR_J: begin
					n_q <= n_q + rc4_pkg::AddrW'(1);
					// key index runs modulo the key length
					if ({1'b0, kidx_q} + rc4_pkg::CountW'(1) == len_q) begin
						kidx_q <= '0;
					end else begin
						kidx_q <= kidx_q + rc4_pkg::AddrW'(1);
					end
					if (n_q == rc4_pkg::AddrW'(rc4_pkg::TableSize - 1)) begin
						i_q     <= '0;
						j_q     <= '0;
						sched_q <= 1'b0;
					end
				end
				default: begin
					sched_q <= sched_q;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (data_acc) begin
			byte_q <= req.data_byte;
		end
		if (state_q == rc4_pkg::ST_D_RD_J || state_q == rc4_pkg::ST_K_SUM) begin
			si_q <= s_rdata;
		end
		if (state_q == rc4_pkg::ST_D_RD_T) begin
			sj_q <= s_rdata;
			t_q  <= t_sum;
		end
		if (state_q == rc4_pkg::ST_D_OUT && out_free) begin
			cipher_q <= byte_q ^ ks_byte;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/rc4_ram.sv =====
// generic single write port ram with registered read, read returns old data
`timescale 1ns / 1ps
`default_nettype none
module rc4_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire
